// ===== rtl/core/bwf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bwf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_RADIUS = 4;

  // Window spans 2R+1 rows and columns; the line store keeps 2R rows above the input row.
  localparam int WIN      = 2 * MAX_RADIUS + 1;
  localparam int SLOTS    = 2 * MAX_RADIUS;
  localparam int WIN_IW   = $clog2(WIN);
  localparam int PIX_IW   = $clog2(MAX_RADIUS + 1);
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int OROW_W   = $clog2(MAX_HEIGHT);
  localparam int IROW_W   = OROW_W + 1;
  localparam int LEAD_W   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

  localparam int PIX_W    = 8;
  localparam int FW_W     = 11;
  localparam int FH_W     = 13;
  localparam int RAD_W    = 3;
  localparam int KEPT_W   = 23;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd4;

  localparam logic MODE_PIXEL   = 1'b0;
  localparam logic MODE_FLUSH   = 1'b1;
  localparam logic SHAPE_SQUARE = 1'b0;
  localparam logic SHAPE_CROSS  = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 3);

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel_in;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel_out;
    logic              last;
    logic [KEPT_W-1:0] kept_count;
  } out_beat_t;

  typedef struct packed {
    logic             fg;
    logic [PIX_W-1:0] pix;
  } slot_t;

  typedef slot_t [SLOTS-1:0] line_word_t;
  localparam int LINE_WORD_W = SLOTS * (PIX_W + 1);

  // One window column: foreground bits of all rows, grey values of the rows
  // that can hold the centre.
  typedef struct packed {
    logic [WIN-1:0]                     fg;
    logic [MAX_RADIUS:0][PIX_W-1:0]     pix;
  } col_t;

endpackage

`default_nettype wire

// ===== rtl/core/binary_erosion_window_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Ports                         | Beat
// input   | in_valid, in_ready, in_data   | mode, pixel_in
// result  | out_valid, out_ready, out_data| pixel_out, last, kept_count
// config  | cfg_we, cfg_index, cfg_data   | one register write, no wait
//
// One beat per cycle sustained while out_ready keeps up; once a beat completes
// its window, the result passes line RAM read, window column shift, result FIFO.
// Reset is synchronous and needs no clearing pass: out-of-frame window
// positions are masked by position. A four-entry result FIFO absorbs output
// stalls; in_ready drops only when it and the pipeline together are full.
module binary_erosion_window_filter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bwf_pkg::in_beat_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bwf_pkg::out_beat_t                out_data,
  input  logic                              cfg_we,
  input  logic [bwf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bwf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bwf_pkg::*;

  // Configuration
  logic [FW_W-1:0]  fw_r;
  logic [FH_W-1:0]  fh_r;
  logic [RAD_W-1:0] rad_r;
  logic             shape_r;
  logic [PIX_W-1:0] thr_r;
  logic             restart;

  logic [FW_W-1:0]  w_eff;
  logic [FH_W-1:0]  h_eff;
  logic [RAD_W-1:0] r_eff;
  logic [LEAD_W:0]  lead_prod;
  logic [LEAD_W-1:0] lead_target;

  // Input side counters
  logic [IROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [OROW_W-1:0] out_row_r, out_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [LEAD_W-1:0] lead_r, lead_nxt;

  logic acc, frame_in, advance, emit, last_in;

  // Stage 1: line RAM read returns
  logic              s1_valid_r, s1_emit_r, s1_last_r;
  logic [COL_W-1:0]  s1_col_r;
  slot_t             s1_slot_r;
  logic [OROW_W-1:0] s1_orow_r;
  logic [COL_W-1:0]  s1_ocol_r;
  logic              byp_sel_r;
  line_word_t        byp_word_r;
  line_word_t        ram_rd, old_word, wr_word;
  col_t              col_new;

  // Stage 2: window held in the cells
  logic              s2_valid_r, s2_emit_r, s2_last_r;
  logic [OROW_W-1:0] s2_orow_r;
  logic [COL_W-1:0]  s2_ocol_r;
  col_t              cols [WIN];
  col_t              cell_in [WIN];
  logic [WIN-1:0]    masks [WIN];
  logic [WIN-1:0]    hits;
  logic [WIN-1:0]    row_ok, col_ok;
  logic [IROW_W:0]   rr;
  logic [COL_W+1:0]  cc;
  logic [RAD_W:0]    two_r;
  logic [PIX_W-1:0]  center_pix;
  logic              center_fg, bg_any, keep, push, pop;
  logic [KEPT_W-1:0] kept_r, kept_sum;
  out_beat_t         res;

  // Result FIFO
  out_beat_t          fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] cnt_r, busy;

  always_comb begin
    w_eff = (fw_r == '0) ? FW_W'(1) : (fw_r > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : fw_r;
    h_eff = (fh_r == '0) ? FH_W'(1) :
            (fh_r > FH_W'(MAX_HEIGHT)) ? FH_W'(MAX_HEIGHT) : fh_r;
    r_eff = (rad_r > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : rad_r;
    lead_prod   = (LEAD_W+1)'(w_eff) * (LEAD_W+1)'(r_eff);
    lead_target = LEAD_W'(lead_prod + (LEAD_W+1)'(r_eff));
  end

  assign restart = cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT ||
                              cfg_index == CFG_RADIUS || cfg_index == CFG_SHAPE ||
                              cfg_index == CFG_THRESHOLD);

  assign busy     = cnt_r + FIFO_CW'(s1_valid_r) + FIFO_CW'(s2_valid_r);
  assign in_ready = busy < FIFO_CW'(FIFO_DEPTH);
  assign acc      = in_valid && in_ready;
  assign frame_in = in_row_r < IROW_W'(h_eff);
  // An early flush beat is consumed without effect.
  assign advance  = acc && !(frame_in && in_data.mode == MODE_FLUSH);
  assign emit     = lead_r == lead_target;
  assign last_in  = emit && ({1'b0, out_row_r} == h_eff - FH_W'(1)) &&
                    ({1'b0, out_col_r} == w_eff - FW_W'(1));

  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    lead_nxt    = lead_r;
    if (restart) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
      lead_nxt    = '0;
    end else if (advance) begin
      if ({1'b0, in_col_r} == w_eff - FW_W'(1)) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + IROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (!emit) begin
        lead_nxt = lead_r + LEAD_W'(1);
      end else if (last_in) begin
        in_row_nxt  = '0;
        in_col_nxt  = '0;
        out_row_nxt = '0;
        out_col_nxt = '0;
        lead_nxt    = '0;
      end else if ({1'b0, out_col_r} == w_eff - FW_W'(1)) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + OROW_W'(1);
      end else begin
        out_col_nxt = out_col_r + COL_W'(1);
      end
    end
  end

  // Each line RAM word holds the 2R rows above the input row at one column.
  bwf_ram #(
    .WIDTH(LINE_WORD_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk    (clk),
    .wr_en  (s1_valid_r),
    .wr_addr(s1_col_r),
    .wr_data(wr_word),
    .rd_en  (advance),
    .rd_addr(in_col_r),
    .rd_data(ram_rd)
  );

  always_comb begin
    // With a one-pixel row the read can hit the word being written.
    old_word   = byp_sel_r ? byp_word_r : ram_rd;
    wr_word[0] = s1_slot_r;
    for (int j = 1; j < SLOTS; j++) begin
      wr_word[j] = old_word[j-1];
    end
    col_new.fg[0]  = s1_slot_r.fg;
    col_new.pix[0] = s1_slot_r.pix;
    for (int k = 1; k < WIN; k++) begin
      col_new.fg[k] = old_word[k-1].fg;
    end
    for (int k = 1; k <= MAX_RADIUS; k++) begin
      col_new.pix[k] = old_word[k-1].pix;
    end
  end

  // Window masks: cell a holds column c+R-a, bit k holds row r+R-k.
  always_comb begin
    two_r = {r_eff, 1'b0};
    rr    = (IROW_W+1)'(s2_orow_r) + (IROW_W+1)'(r_eff);
    cc    = (COL_W+2)'(s2_ocol_r) + (COL_W+2)'(r_eff);
    for (int k = 0; k < WIN; k++) begin
      row_ok[k] = ((RAD_W+1)'(k) <= two_r) && (rr >= (IROW_W+1)'(k)) &&
                  ((rr - (IROW_W+1)'(k)) < (IROW_W+1)'(h_eff));
      col_ok[k] = ((RAD_W+1)'(k) <= two_r) && (cc >= (COL_W+2)'(k)) &&
                  ((cc - (COL_W+2)'(k)) < (COL_W+2)'(w_eff));
    end
    for (int a = 0; a < WIN; a++) begin
      for (int k = 0; k < WIN; k++) begin
        if (shape_r == SHAPE_CROSS) begin
          masks[a][k] = row_ok[k] && col_ok[a] &&
                        (((RAD_W+1)'(a) == (RAD_W+1)'(r_eff)) ||
                         ((RAD_W+1)'(k) == (RAD_W+1)'(r_eff)));
        end else begin
          masks[a][k] = row_ok[k] && col_ok[a];
        end
      end
    end
  end

  always_comb begin
    cell_in[0] = col_new;
    for (int a = 1; a < WIN; a++) begin
      cell_in[a] = cols[a-1];
    end
  end

  for (genvar a = 0; a < WIN; a++) begin : g_cell
    bwf_cell u_cell (
      .clk     (clk),
      .shift_en(s1_valid_r),
      .col_in  (cell_in[a]),
      .col_out (cols[a]),
      .mask    (masks[a]),
      .bg_hit  (hits[a])
    );
  end

  always_comb begin
    center_pix = cols[WIN_IW'(r_eff)].pix[PIX_IW'(r_eff)];
    center_fg  = center_pix > thr_r;
    bg_any     = |hits;
    keep       = center_fg && !bg_any;
    kept_sum   = kept_r + KEPT_W'(keep);
    push       = s2_valid_r && s2_emit_r;
    res.pixel_out  = (center_fg && bg_any) ? thr_r : center_pix;
    res.last       = s2_last_r;
    res.kept_count = s2_last_r ? kept_sum : '0;
  end

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != '0;
  assign out_data  = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r       <= FW_W'(1024);
      fh_r       <= FH_W'(1024);
      rad_r      <= RAD_W'(1);
      shape_r    <= SHAPE_SQUARE;
      thr_r      <= '0;
      in_row_r   <= '0;
      in_col_r   <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      lead_r     <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      kept_r     <= '0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  fw_r    <= cfg_data[FW_W-1:0];
          CFG_FRAME_HEIGHT: fh_r    <= cfg_data[FH_W-1:0];
          CFG_RADIUS:       rad_r   <= cfg_data[RAD_W-1:0];
          CFG_SHAPE:        shape_r <= cfg_data[0];
          CFG_THRESHOLD:    thr_r   <= cfg_data[PIX_W-1:0];
          default: ;
        endcase
      end
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      lead_r     <= lead_nxt;
      s1_valid_r <= advance;
      s2_valid_r <= s1_valid_r;
      if (restart) begin
        kept_r <= '0;
      end else if (push) begin
        kept_r <= s2_last_r ? '0 : kept_sum;
      end
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_r + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_col_r      <= in_col_r;
      s1_slot_r.fg  <= frame_in && (in_data.pixel_in > thr_r);
      s1_slot_r.pix <= in_data.pixel_in;
      s1_emit_r     <= emit;
      s1_last_r     <= last_in;
      s1_orow_r     <= out_row_r;
      s1_ocol_r     <= out_col_r;
      byp_sel_r     <= s1_valid_r && (s1_col_r == in_col_r);
      byp_word_r    <= wr_word;
    end
    if (s1_valid_r) begin
      s2_emit_r <= s1_emit_r;
      s2_last_r <= s1_last_r;
      s2_orow_r <= s1_orow_r;
      s2_ocol_r <= s1_ocol_r;
    end
    if (push) begin
      fifo_r[wr_ptr_r] <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bwf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/bwf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bwf_cell (
  input  logic                   clk,
  input  logic                   shift_en,
  input  bwf_pkg::col_t          col_in,
  output bwf_pkg::col_t          col_out,
  input  logic [bwf_pkg::WIN-1:0] mask,
  output logic                   bg_hit
);
  import bwf_pkg::*;

  col_t col_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;
  assign bg_hit  = |(~col_r.fg & mask);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bwf_pkg::*;

  localparam int STORE_DEPTH = 2 * MAX_RADIUS * (MAX_WIDTH + 1) + 1;
  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_beat_t in_data;
  logic out_valid;
  logic out_ready;
  out_beat_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  binary_erosion_window_filter_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Mirror of the block's state, used to work out the eroded pixels.
  logic [PIX_W-1:0] pix_mirror [0:STORE_DEPTH-1];
  int unsigned in_r, in_c, out_r, out_c, kept_sum;
  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;
  logic [RAD_W-1:0] radius_reg;
  logic shape_reg;
  logic [PIX_W-1:0] thresh_reg;
  bit frame_done;

  out_beat_t eroded_q[$];
  int errors;
  int idle_pct;
  int stall_pct;
  int hold_req;
  int hold_cnt;
  int quiet_cycles;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int unsigned eff_w();
    return (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
  endfunction

  function automatic int unsigned eff_h();
    return (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
  endfunction

  function automatic int unsigned eff_rad();
    return (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
  endfunction

  function automatic int unsigned mirror_addr(int unsigned r, int unsigned c, int unsigned w);
    return (r * w + c) % STORE_DEPTH;
  endfunction

  function automatic bit is_background(int unsigned r, int unsigned c, int unsigned w);
    return pix_mirror[mirror_addr(r, c, w)] <= thresh_reg;
  endfunction

  // True when no background pixel lies under the element centered at (r, c).
  function automatic bit element_fits(int unsigned r, int unsigned c, int unsigned w,
                                      int unsigned h, int unsigned rad);
    int unsigned r0, r1, c0, c1;
    r0 = (r >= rad) ? r - rad : 0;
    r1 = (r + rad > h - 1) ? h - 1 : r + rad;
    c0 = (c >= rad) ? c - rad : 0;
    c1 = (c + rad > w - 1) ? w - 1 : c + rad;
    if (shape_reg == SHAPE_SQUARE) begin
      for (int unsigned y = r0; y <= r1; y++)
        for (int unsigned x = c0; x <= c1; x++)
          if (is_background(y, x, w)) return 1'b0;
    end else begin
      for (int unsigned y = r0; y <= r1; y++)
        if (is_background(y, c, w)) return 1'b0;
      for (int unsigned x = c0; x <= c1; x++)
        if (is_background(r, x, w)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void restart_positions();
    in_r = 0;
    in_c = 0;
    out_r = 0;
    out_c = 0;
    kept_sum = 0;
  endfunction

  function automatic void predict_erosion(in_beat_t b);
    int unsigned w, h, rad, pos;
    logic [PIX_W-1:0] center;
    out_beat_t res;
    bit is_last;
    w = eff_w();
    h = eff_h();
    rad = eff_rad();
    if (in_r < h) begin
      if (b.mode == MODE_FLUSH) return;
      pix_mirror[mirror_addr(in_r, in_c, w)] = b.pixel_in;
    end
    pos = in_r * w + in_c;
    in_c++;
    if (in_c >= w) begin
      in_c = 0;
      in_r++;
    end
    if (pos < rad * w + rad) return;
    center = pix_mirror[mirror_addr(out_r, out_c, w)];
    res.pixel_out = center;
    if (center > thresh_reg) begin
      if (element_fits(out_r, out_c, w, h, rad)) kept_sum++;
      else res.pixel_out = thresh_reg;
    end
    is_last = (out_r == h - 1) && (out_c == w - 1);
    res.last = is_last;
    res.kept_count = is_last ? kept_sum[KEPT_W-1:0] : '0;
    eroded_q.push_back(res);
    if (is_last) begin
      restart_positions();
      frame_done = 1'b1;
    end else begin
      out_c++;
      if (out_c >= w) begin
        out_c = 0;
        out_r++;
      end
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(logic m, logic [PIX_W-1:0] p);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{mode: m, pixel_in: p};
    do @(posedge clk); while (!in_ready);
    predict_erosion('{mode: m, pixel_in: p});
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:  width_reg = val[FW_W-1:0];
      CFG_FRAME_HEIGHT: height_reg = val[FH_W-1:0];
      CFG_RADIUS:       radius_reg = val[RAD_W-1:0];
      CFG_SHAPE:        shape_reg = val[0];
      CFG_THRESHOLD:    thresh_reg = val[PIX_W-1:0];
      default: ;
    endcase
    restart_positions();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (eroded_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic setup_frame(int w, int h, int rad, logic shp, int thr);
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_RADIUS, CFG_DATA_W'(rad));
    write_reg(CFG_SHAPE, CFG_DATA_W'(shp));
    write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(int fg_pct);
    if (thresh_reg != 8'hFF && $urandom_range(99) < fg_pct)
      return PIX_W'($urandom_range(255, 32'(thresh_reg) + 1));
    return PIX_W'($urandom_range(255));
  endfunction

  // Streams one whole frame plus the flush beats that push it out.
  // With noise on, stray flushes fall inside the frame and surplus pixels after it.
  task automatic stream_frame(int fg_pct, bit noise, int pause_at);
    int unsigned total, sent;
    total = eff_w() * eff_h();
    sent = 0;
    frame_done = 1'b0;
    while (!frame_done) begin
      if (sent == pause_at) begin
        drain();
        pause_at = -1;
      end else if (sent < total) begin
        if (noise && $urandom_range(99) < 8) send_beat(MODE_FLUSH, PIX_W'($urandom_range(255)));
        else begin
          send_beat(MODE_PIXEL, pick_pixel(fg_pct));
          sent++;
        end
      end else if (noise && $urandom_range(99) < 30) begin
        send_beat(MODE_PIXEL, PIX_W'($urandom_range(255)));
      end else begin
        send_beat(MODE_FLUSH, PIX_W'($urandom_range(255)));
      end
    end
    if (noise) repeat (2) send_beat(MODE_FLUSH, 8'h00);
    drain();
  endtask

  task automatic test_small_cases();
    setup_frame(1, 1, 0, SHAPE_SQUARE, 0);
    stream_frame(50, 0, -1);
    setup_frame(1, 1, 1, SHAPE_CROSS, 0);
    stream_frame(50, 0, -1);
    setup_frame(3, 3, 1, SHAPE_SQUARE, 100);
    send_beat(MODE_PIXEL, 8'h00);
    send_beat(MODE_PIXEL, 8'hFF);
    send_beat(MODE_PIXEL, 8'h64);
    send_beat(MODE_PIXEL, 8'h65);
    send_beat(MODE_FLUSH, 8'hAA);
    send_beat(MODE_PIXEL, 8'h55);
    send_beat(MODE_PIXEL, 8'hC8);
    send_beat(MODE_PIXEL, 8'hFE);
    send_beat(MODE_PIXEL, 8'h80);
    send_beat(MODE_PIXEL, 8'h7F);
    frame_done = 1'b0;
    while (!frame_done) send_beat(MODE_PIXEL, 8'h01);
    drain();
    // Saturated sizes: width and height written as zero, radius above its maximum.
    setup_frame(0, 0, 7, SHAPE_CROSS, 0);
    stream_frame(50, 1, -1);
    setup_frame(5, 4, 5, SHAPE_SQUARE, 255);
    stream_frame(50, 0, -1);
    setup_frame(6, 6, 2, SHAPE_CROSS, 0);
    stream_frame(95, 1, -1);
  endtask

  task automatic test_size_extremes();
    setup_frame(16, 1, 1, SHAPE_SQUARE, 20);
    stream_frame(97, 0, -1);
    setup_frame(1, 20, 4, SHAPE_CROSS, 200);
    stream_frame(60, 0, -1);
    setup_frame(2, 12, 3, SHAPE_SQUARE, 10);
    stream_frame(97, 0, -1);
  endtask

  task automatic test_random_frames(int pixels);
    int done_pix;
    done_pix = 0;
    while (done_pix < pixels) begin
      setup_frame($urandom_range(10, 1), $urandom_range(8, 1), $urandom_range(4),
                  1'($urandom_range(1)), ($urandom_range(3) == 0) ? $urandom_range(255)
                                                                  : $urandom_range(60));
      done_pix += eff_w() * eff_h();
      stream_frame($urandom_range(99, 70), $urandom_range(3) == 0, -1);
    end
  endtask

  task automatic test_backpressure();
    setup_frame(8, 6, 2, SHAPE_SQUARE, 30);
    hold_req = 300;
    stream_frame(90, 0, -1);
  endtask

  task automatic test_drain_pause();
    setup_frame(6, 5, 2, SHAPE_CROSS, 40);
    stream_frame(90, 0, 15);
  endtask

  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    out_beat_t exp_beat;
    if (rst_n && out_valid && out_ready) begin
      if (eroded_q.size() == 0) begin
        $display("%0t: unexpected beat %p", $time, out_data);
        errors++;
      end else begin
        exp_beat = eroded_q.pop_front();
        if (out_data.pixel_out !== exp_beat.pixel_out) begin
          $display("%0t: pixel_out expected %0d actual %0d", $time,
                   exp_beat.pixel_out, out_data.pixel_out);
          errors++;
        end
        if (out_data.last !== exp_beat.last) begin
          $display("%0t: last expected %0d actual %0d", $time, exp_beat.last, out_data.last);
          errors++;
        end
        if (out_data.kept_count !== exp_beat.kept_count) begin
          $display("%0t: kept_count expected %0d actual %0d", $time,
                   exp_beat.kept_count, out_data.kept_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_cnt = 0;
    quiet_cycles = 0;
    frame_done = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) pix_mirror[i] = '0;
    restart_positions();
    width_reg = 11'd1024;
    height_reg = 13'd1024;
    radius_reg = 3'd1;
    shape_reg = SHAPE_SQUARE;
    thresh_reg = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_small_cases();
    test_size_extremes();
    test_backpressure();
    test_drain_pause();
    test_random_frames(30);
    idle_pct = 77;
    test_random_frames(24);
    idle_pct = 0;
    stall_pct = 77;
    test_random_frames(24);
    idle_pct = 10;
    stall_pct = 10;
    test_random_frames(24);
    test_drain_pause();

    drain();
    if (errors == 0 && eroded_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bwf_pkg.sv
rtl/core/bwf_ram.sv
rtl/core/bwf_cell.sv
rtl/core/binary_erosion_window_filter_core.sv
tb/tb.sv
